// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define BFA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// signal is stable in the cycle after the condition
`define BFA_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
    `BFA_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig), msg)

`endif

// ----- sv/bfa_pkg.sv -----
`default_nettype none
package bfa_pkg;

    localparam int ENTRIES = 1024;
    localparam int WORD_W  = 32;
    localparam int WORDS   = (ENTRIES + WORD_W - 1) / WORD_W;
    localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int XW      = 17;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int ST_W   = 2;
    localparam int OCNT_W = 11;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL         = 2'd1;
    localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WA_W-1:0]   waddr_t;

    typedef struct packed {
        logic   rd_en;
        waddr_t rd_addr;
        logic   wr_en;
        waddr_t wr_addr;
        word_t  wr_data;
        logic   clear;
    } mem_req_t;

    // bits of a word that lie past the end of the map, treated as used
    function automatic word_t pad_mask(waddr_t w);
        word_t m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = ((int'(w) * WORD_W + b) >= ENTRIES);
        end
        return m;
    endfunction

    // lowest clear bit of a word
    function automatic logic [BIT_W-1:0] first_zero(word_t w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/bfa_map_store.sv -----
`default_nettype none
module bfa_map_store
    import bfa_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mem_req_t req,
    output word_t         rd_data
);

    word_t            mem [WORDS];
    logic [WORDS-1:0] valid_reg;
    word_t            rd_q_reg;
    logic             rd_valid_reg;
    logic             rd_zero_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg     <= mem[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
            rd_zero_reg  <= (req.rd_addr == '0);
        end
    end

    // a row never written since reset or format reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : (rd_zero_reg ? word_t'(1) : '0);

endmodule
`default_nettype wire

// ----- sv/bfa_ctrl.sv -----
`default_nettype none
module bfa_ctrl
    import bfa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   in_op,
    input  wire logic [IDX_W-1:0]  in_idx,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ST_W-1:0]        out_status,
    output logic [IDX_W-1:0]       out_granted,
    output logic [OCNT_W-1:0]      out_count,
    output mem_req_t               mem_req,
    input  wire word_t             rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FWR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [WA_W:0]     scan_reg, scan_next;
    logic              pend_reg, pend_next;
    waddr_t            chk_reg, chk_next;
    waddr_t            fword_reg, fword_next;
    logic [BIT_W-1:0]  fbit_reg, fbit_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_granted_reg, res_granted_next;
    logic              m_valid_reg, m_valid_next;
    logic [ST_W-1:0]   m_status_reg, m_status_next;
    logic [IDX_W-1:0]  m_granted_reg, m_granted_next;
    logic [OCNT_W-1:0] m_count_reg, m_count_next;

    logic [XW-1:0]     idx_x;
    word_t             eff;
    logic [BIT_W-1:0]  zb;
    logic [XW-1:0]     gx;
    logic [XW-1:0]     cx;

    assign idx_x = XW'(in_idx);

    always_comb begin
        state_next       = state_reg;
        scan_next        = scan_reg;
        pend_next        = pend_reg;
        chk_next         = chk_reg;
        fword_next       = fword_reg;
        fbit_next        = fbit_reg;
        used_next        = used_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_granted_next   = m_granted_reg;
        m_count_next     = m_count_reg;
        mem_req          = '0;
        eff              = rd_data | pad_mask(chk_reg);
        zb               = first_zero(eff);
        gx               = (XW'(chk_reg) << BIT_W) | XW'(zb);
        cx               = XW'(used_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_status_next  = ST_OK;
                    res_granted_next = '0;
                    state_next       = S_DONE;
                    case (in_op)
                        OP_ALLOC: begin
                            if (used_reg == CNT_W'(ENTRIES)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                scan_next  = '0;
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (idx_x < XW'(ENTRIES)) begin
                                fword_next = idx_x[BIT_W +: WA_W];
                                fbit_next  = idx_x[BIT_W-1:0];
                                state_next = S_FRD;
                            end else begin
                                res_status_next = ST_ALREADY_FREE;
                            end
                        end
                        OP_FORMAT: begin
                            mem_req.clear = 1'b1;
                            used_next     = CNT_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // next word is read while the previous one is checked
                if (scan_reg < (WA_W+1)'(WORDS)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[WA_W-1:0];
                end
                scan_next = scan_reg + 1'b1;
                pend_next = 1'b1;
                chk_next  = scan_reg[WA_W-1:0];
                if (pend_reg && !(&eff)) begin
                    mem_req.wr_en    = 1'b1;
                    mem_req.wr_addr  = chk_reg;
                    mem_req.wr_data  = rd_data | (word_t'(1) << zb);
                    used_next        = used_reg + 1'b1;
                    res_granted_next = gx[IDX_W-1:0];
                    state_next       = S_DONE;
                end
            end
            S_FRD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = fword_reg;
                state_next      = S_FWR;
            end
            S_FWR: begin
                if (rd_data[fbit_reg]) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = fword_reg;
                    mem_req.wr_data = rd_data & ~(word_t'(1) << fbit_reg);
                    used_next       = used_reg - 1'b1;
                end else begin
                    res_status_next = ST_ALREADY_FREE;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_granted_next = res_granted_reg;
                    m_count_next   = cx[OCNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= CNT_W'(1);
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg        <= scan_next;
        chk_reg         <= chk_next;
        fword_reg       <= fword_next;
        fbit_reg        <= fbit_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        m_status_reg    <= m_status_next;
        m_granted_reg   <= m_granted_next;
        m_count_reg     <= m_count_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign out_status  = m_status_reg;
    assign out_granted = m_granted_reg;
    assign out_count   = m_count_reg;

endmodule
`default_nettype wire

// ----- sv/bitmap_first_free_allocator_core.sv -----
// channel   direction  tdata                                   tuser
// s_        in         [9:0] entry_index, [15:10] zero          [1:0] op
// m_        out        [9:0] granted_index, [20:10] used_count  [1:0] status
//
// one transaction at a time; format, full allocate and unused op go straight to the result,
// free reads the map word and then writes it back, and allocate reads the 32-bit map words
// of the map memory in order until the first word with a free entry and takes its lowest free bit
// reset clears the per-word valid bits at once; no clearing pass, ready right after reset
// a result waits in the output register while the next request runs; that request
// then holds in its final state until the output register empties
`default_nettype none
module bitmap_first_free_allocator_core
    import bfa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [9:0] entry_index, [15:10] zero
    input  wire logic [1:0]  s_tuser,  // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // [9:0] granted_index, [20:10] used_count, [23:21] zero
    output logic [1:0]       m_tuser   // [1:0] status
);

    mem_req_t          mem_req;
    word_t             rd_data;
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  granted;
    logic [OCNT_W-1:0] count;

    bfa_map_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    bfa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .in_op       (s_tuser),
        .in_idx      (s_tdata[IDX_W-1:0]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .out_status  (status),
        .out_granted (granted),
        .out_count   (count),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    assign m_tdata = {3'b000, count, granted};
    assign m_tuser = status;

endmodule
`default_nettype wire

// ----- sv/bfa_checker.sv -----
`include "assert_macros.svh"
`default_nettype none
module bfa_checker
    import bfa_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    localparam logic [OCNT_W-1:0] FULL_CNT = OCNT_W'(ENTRIES);

    logic [IDX_W-1:0]  m_grant;
    logic [OCNT_W-1:0] m_count;
    logic              full_out;
    logic              full_ok;
    logic              refused_out;

    assign m_grant     = m_tdata[IDX_W-1:0];
    assign m_count     = m_tdata[IDX_W +: OCNT_W];
    assign full_out    = m_tvalid && (m_tuser == ST_FULL);
    assign full_ok     = (m_grant == '0) && (m_count == FULL_CNT);
    assign refused_out = m_tvalid && (m_tuser == ST_ALREADY_FREE);

    `BFA_ASSERT_HOLD(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tdata, "stall change")
    `BFA_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "busy accept")
    `BFA_ASSERT(a_full_result, aclk, aresetn, full_out |-> full_ok, "bad full answer")
    `BFA_ASSERT(a_free_no_grant, aclk, aresetn, refused_out |-> m_grant == '0, "refused grant")

endmodule

bind bitmap_first_free_allocator_core bfa_checker u_bfa_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bfa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 150;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  granted;
        logic [OCNT_W-1:0] count;
    } alloc_result_t;

    class alloc_scoreboard;
        bit            in_use [ENTRIES];
        int unsigned   used;
        alloc_result_t expected_q [$];
        int unsigned   errors;
        int unsigned   n_requests;
        int unsigned   n_granted;
        int unsigned   n_full;
        int unsigned   n_refused;
        int unsigned   n_formats;

        function new();
            format_map();
        endfunction

        function void format_map();
            foreach (in_use[i]) in_use[i] = 1'b0;
            in_use[0] = 1'b1;
            used = 1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the map for an accepted request and queue the answer it must give
        function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
            alloc_result_t r;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_ALLOC: begin
                    r.status = ST_FULL;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!in_use[i]) begin
                            in_use[i] = 1'b1;
                            used++;
                            r.status = ST_OK;
                            r.granted = IDX_W'(i);
                            break;
                        end
                    end
                    if (r.status == ST_FULL) n_full++;
                    else n_granted++;
                end
                OP_FREE: begin
                    if (int'(idx) < ENTRIES && in_use[idx]) begin
                        in_use[idx] = 1'b0;
                        used--;
                    end else begin
                        r.status = ST_ALREADY_FREE;
                        n_refused++;
                    end
                end
                OP_FORMAT: begin
                    format_map();
                    n_formats++;
                end
                default: ;
            endcase
            r.count = OCNT_W'(used);
            expected_q.push_back(r);
            n_requests++;
        endfunction

        function void check_result(logic [ST_W-1:0] status, logic [IDX_W-1:0] granted,
                                   logic [OCNT_W-1:0] count);
            alloc_result_t exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction: status %0d index %0d count %0d",
                         $time, status, granted, count);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (status !== exp.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp.status, status);
                errors++;
            end
            if (granted !== exp.granted) begin
                $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                         $time, exp.granted, granted);
                errors++;
            end
            if (count !== exp.count) begin
                $display("%0t: used_count mismatch, expected %0d, actual %0d",
                         $time, exp.count, count);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    alloc_scoreboard sb;
    bit              steady = 1'b0;
    int unsigned     cycles = 0;

    bitmap_first_free_allocator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata[9:0], m_tdata[20:10]);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        while (!steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, idx};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, idx);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int unsigned      r;
        int unsigned      k;
        logic [IDX_W-1:0] idx;

        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state, reuse of a freed slot, entry zero, double free, unused op, format
        send_request(OP_ALLOC, 10'h3FF);
        send_request(OP_ALLOC, 10'h000);
        send_request(OP_ALLOC, 10'h155);
        send_request(OP_FREE, 10'd2);
        send_request(OP_ALLOC, 10'h2AA);
        send_request(OP_FREE, 10'd2);
        send_request(OP_FREE, 10'd2);
        send_request(OP_FREE, 10'd0);
        send_request(OP_ALLOC, 10'h000);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_FREE, 10'd512);
        send_request(OP_UNUSED, 10'h3FF);
        send_request(OP_UNUSED, 10'h000);
        send_request(OP_FORMAT, 10'h2AA);
        send_request(OP_ALLOC, 10'h155);
        send_request(OP_FREE, 10'd1);
        send_request(OP_FREE, 10'd1);
        send_request(OP_ALLOC, 10'h3FF);
        send_request(OP_FREE, 10'd0);
        send_request(OP_FORMAT, 10'h3FF);

        // fill the whole map, then run into the full condition
        while (sb.used < ENTRIES) send_request(OP_ALLOC, IDX_W'($urandom_range(0, 1023)));
        repeat (3) send_request(OP_ALLOC, IDX_W'($urandom_range(0, 1023)));
        send_request(OP_FREE, 10'd1023);
        send_request(OP_FREE, 10'd512);
        send_request(OP_FREE, 10'd0);
        repeat (4) send_request(OP_ALLOC, 10'h000);
        send_request(OP_FREE, 10'd1023);
        drain_results();
        send_request(OP_FORMAT, 10'h000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 40 && n < 110);
            r = $urandom_range(0, 99);
            idx = IDX_W'($urandom_range(0, 1023));
            if (r < 55) begin
                send_request(OP_ALLOC, idx);
            end else if (r < 85) begin
                // free an entry that is actually in use, found from a random start
                if (sb.used != 0) begin
                    k = idx;
                    while (!sb.in_use[k]) k = (k + 1) % ENTRIES;
                    idx = IDX_W'(k);
                end
                send_request(OP_FREE, idx);
            end else if (r < 95) begin
                send_request(OP_FREE, idx);
            end else if (r < 98) begin
                send_request(OP_UNUSED, idx);
            end else begin
                send_request(OP_FORMAT, idx);
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (40) @(posedge aclk);

        $display("covered %0d requests: %0d grants, %0d allocations refused on a full map,",
                 sb.n_requests, sb.n_granted, sb.n_full);
        $display("%0d frees of free entries, %0d formats, %0d mismatches",
                 sb.n_refused, sb.n_formats, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_map_store.sv
sv/bfa_ctrl.sv
sv/bitmap_first_free_allocator_core.sv
sv/bfa_checker.sv
tb/sv/testbench.sv
